### sv/timestamp_parse_weekday_assert.svh
// Assertion macros shared by the time-message parser modules.
// Depends on a clock named clk and a reset named rst in the module that uses them.
`ifndef TIMESTAMP_PARSE_WEEKDAY_ASSERT_SVH
`define TIMESTAMP_PARSE_WEEKDAY_ASSERT_SVH
`ifndef SYNTHESIS
`define TSPW_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: property failed");
`define TSPW_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("%m: forbidden condition seen");
`else
`define TSPW_ASSERT(label, prop)
`define TSPW_NEVER(label, cond)
`endif
`endif

### sv/tspw_pkg.sv
// Package for the time-message parser: record type, positions and month table.
// Used by every module of the block; depends on nothing.
package tspw_pkg;

  localparam int unsigned TSPW_QDEPTH = 2;

  localparam logic [4:0] POS_FIRST = 5'd2;
  localparam logic [4:0] POS_LAST  = 5'd18;
  localparam logic [4:0] POS_LIMIT = 5'd20;

  localparam logic [3:0] MONTH_MAX = 4'd12;
  localparam logic [4:0] DAY_MAX   = 5'd31;
  localparam logic [6:0] HOUR_MAX  = 7'd23;
  localparam logic [6:0] MIN_MAX   = 7'd59;

  typedef struct packed {
    logic       ok;
    logic [6:0] yy;
    logic [3:0] mo;
    logic [4:0] dd;
    logic [4:0] hh;
    logic [5:0] mi;
    logic [5:0] ss;
  } tspw_rec_t;

  function automatic logic [2:0] month_off(input logic [3:0] mo);
    logic [2:0] off;
    unique case (mo)
      4'd1:    off = 3'd0;
      4'd2:    off = 3'd3;
      4'd3:    off = 3'd2;
      4'd4:    off = 3'd5;
      4'd5:    off = 3'd0;
      4'd6:    off = 3'd3;
      4'd7:    off = 3'd5;
      4'd8:    off = 3'd1;
      4'd9:    off = 3'd4;
      4'd10:   off = 3'd6;
      4'd11:   off = 3'd2;
      4'd12:   off = 3'd4;
      default: off = 3'd0;
    endcase
    return off;
  endfunction

endpackage

### sv/tspw_front.sv
// Front end: counts bytes, checks digits, builds the six fields and the result record.
// Depends on tspw_pkg; feeds tspw_fifo.
module tspw_front import tspw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_byte,
  input  logic       end_of_message,
  input  logic       q_full,
  output logic       rec_push,
  output tspw_rec_t  rec
);

  typedef enum logic [1:0] {PH_UNITS = 2'd0, PH_SEP = 2'd1, PH_TENS = 2'd2} phase_t;

  logic [4:0] pos;
  phase_t     phase;
  phase_t     phase_next;
  logic [3:0] tens;
  logic [2:0] fidx;
  logic       ferr;
  logic [6:0] fields [6];

  logic       accept;
  logic       is_digit;
  logic [3:0] val;
  logic       dig_pos;
  logic [6:0] f_now;
  logic       err_now;
  logic       ok;

  assign full     = q_full;
  assign accept   = push && !q_full;
  assign rec_push = accept && end_of_message;

  assign is_digit = (char_byte >= 8'h30) && (char_byte <= 8'h39);
  assign val      = is_digit ? char_byte[3:0] : 4'd0;
  assign dig_pos  = (pos >= POS_FIRST) && (pos <= POS_LAST) && (phase != PH_SEP);
  assign f_now    = is_digit ? 7'(7'(tens) * 7'd10 + 7'(val)) : 7'd0;
  assign err_now  = ferr || (dig_pos && !is_digit);

  always_comb begin
    unique case (phase)
      PH_UNITS: phase_next = PH_SEP;
      PH_SEP:   phase_next = PH_TENS;
      PH_TENS:  phase_next = PH_UNITS;
      default:  phase_next = PH_UNITS;
    endcase
  end

  always_comb begin
    ok = !err_now && (pos == POS_LAST)
      && (fields[1] >= 7'd1) && (fields[1] <= 7'(MONTH_MAX))
      && (fields[2] >= 7'd1) && (fields[2] <= 7'(DAY_MAX))
      && (fields[3] <= HOUR_MAX) && (fields[4] <= MIN_MAX) && (f_now <= MIN_MAX);
    rec = '0;
    if (ok) begin
      rec.ok = 1'b1;
      rec.yy = fields[0];
      rec.mo = fields[1][3:0];
      rec.dd = fields[2][4:0];
      rec.hh = fields[3][4:0];
      rec.mi = fields[4][5:0];
      rec.ss = f_now[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      phase <= PH_UNITS;
      fidx  <= '0;
      ferr  <= 1'b0;
    end else if (accept) begin
      if (end_of_message) begin
        pos   <= '0;
        phase <= PH_UNITS;
        fidx  <= '0;
        ferr  <= 1'b0;
      end else begin
        if (pos < POS_LIMIT) begin
          pos <= pos + 5'd1;
        end
        phase <= phase_next;
        ferr  <= err_now;
        if (dig_pos && phase == PH_TENS) begin
          tens <= val;
        end
        if (dig_pos && phase == PH_UNITS) begin
          fields[fidx] <= f_now;
          fidx         <= fidx + 3'd1;
        end
      end
    end
  end

endmodule

### sv/tspw_fifo.sv
// Short register queue carrying result records from front end to back end.
// Depends on tspw_pkg and the shared assertion macros.
`include "timestamp_parse_weekday_assert.svh"
module tspw_fifo import tspw_pkg::*; #(
  parameter int unsigned DEPTH = TSPW_QDEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      wr_en,
  input  tspw_rec_t wr_data,
  output logic      full,
  input  logic      rd_en,
  output tspw_rec_t rd_data,
  output logic      empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  tspw_rec_t     mem [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [CW-1:0] cnt;
  logic          do_wr;
  logic          do_rd;

  assign full    = (cnt == CNT_FULL);
  assign empty   = (cnt == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PTR_LAST) ? '0 : wptr + AW'(1);
      end
      if (do_rd) begin
        rptr <= (rptr == PTR_LAST) ? '0 : rptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt <= cnt + CW'(1);
      end else if (do_rd && !do_wr) begin
        cnt <= cnt - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wr_data;
    end
  end

  `TSPW_NEVER(a_cnt_range, cnt > CNT_FULL)
  `TSPW_ASSERT(a_cnt_up, (do_wr && !do_rd) |=> cnt == $past(cnt) + CW'(1))
  `TSPW_ASSERT(a_ptr_match, (cnt == '0 || cnt == CNT_FULL) |-> wptr == rptr)

endmodule

### sv/tspw_back.sv
// Back end: forms the weekday sum, reduces it mod 7 and holds the result register.
// Depends on tspw_pkg and the shared assertion macros; reads from tspw_fifo.
`include "timestamp_parse_weekday_assert.svh"
module tspw_back import tspw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  tspw_rec_t  q_data,
  output logic       q_pop,
  output logic       empty,
  input  logic       pop,
  output logic       accepted,
  output logic [6:0] year_of_century,
  output logic [3:0] month_number,
  output logic [4:0] day_of_month,
  output logic [4:0] hour_value,
  output logic [5:0] minute_value,
  output logic [5:0] second_value,
  output logic [2:0] weekday_number
);

  logic       v1;
  tspw_rec_t  rec1;
  logic [7:0] sum1;
  logic       ov;
  tspw_rec_t  orec;
  logic [2:0] owd;

  logic        out_load;
  logic        s1_load;
  logic [6:0]  t;
  logic [6:0]  t4;
  logic [7:0]  sum;
  logic [13:0] prod;
  logic [4:0]  quo;
  logic [3:0]  rem;
  logic [2:0]  wd;

  assign out_load = v1 && (!ov || pop);
  assign s1_load  = !q_empty && (!v1 || out_load);
  assign q_pop    = s1_load;

  // year offset from 1999, shifted past February
  assign t   = q_data.yy + ((q_data.mo >= 4'd3) ? 7'd1 : 7'd0);
  assign t4  = 7'((t + 7'd3) >> 2);
  assign sum = 8'd5 + 8'(t) + 8'(t4) + 8'(month_off(q_data.mo)) + 8'(q_data.dd);

  assign prod = 14'(sum1) * 14'd73;
  assign quo  = prod[13:9];
  assign rem  = 4'(sum1 - 8'(quo) * 8'd7);
  assign wd   = (rem >= 4'd7) ? 3'(rem - 4'd7) : rem[2:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      ov <= 1'b0;
    end else begin
      if (s1_load) begin
        v1 <= 1'b1;
      end else if (out_load) begin
        v1 <= 1'b0;
      end
      if (out_load) begin
        ov <= 1'b1;
      end else if (pop) begin
        ov <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      rec1 <= q_data;
      sum1 <= sum;
    end
    if (out_load) begin
      orec <= rec1;
      owd  <= rec1.ok ? wd : 3'd0;
    end
  end

  assign empty           = !ov;
  assign accepted        = orec.ok;
  assign year_of_century = orec.yy;
  assign month_number    = orec.mo;
  assign day_of_month    = orec.dd;
  assign hour_value      = orec.hh;
  assign minute_value    = orec.mi;
  assign second_value    = orec.ss;
  assign weekday_number  = owd;

  `TSPW_NEVER(a_wd_range, ov && owd > 3'd6)
  `TSPW_NEVER(a_reject_zero, ov && !orec.ok && (owd != 3'd0 || orec.mo != 4'd0))
  `TSPW_NEVER(a_accept_date, ov && orec.ok && (orec.mo == 4'd0 || orec.dd == 5'd0))

endmodule

### sv/timestamp_parse_weekday.sv
// Time-setting message parser with day of week.
// Input queue side: one message byte per transfer on char_byte, with
// end_of_message on the last byte; a byte transfers when push is high and
// full is low. Result queue side: while empty is low the oldest result sits
// on the result ports; it transfers when pop is high.
// Each message gives one result on its last byte: accepted, the six
// fields and weekday_number (0 Sunday); a rejected message reads as zeros.
// A byte is taken every cycle while full is low. A result passes through
// the record queue, the sum stage and the result register, then shows with empty low.
// A two-entry record queue parts the byte counter from the weekday path,
// so when pop stays low, bytes keep flowing until three further results
// pile up behind the held one; full then rises until pop resumes.
// Reset (rst, synchronous) drops any partial message and all waiting
// results; the next byte starts a new message.
// Depends on tspw_pkg, tspw_front, tspw_fifo and tspw_back.
module timestamp_parse_weekday import tspw_pkg::*; #(
  parameter int unsigned QDEPTH = TSPW_QDEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_byte,
  input  logic       end_of_message,
  output logic       empty,
  input  logic       pop,
  output logic       accepted,
  output logic [6:0] year_of_century,
  output logic [3:0] month_number,
  output logic [4:0] day_of_month,
  output logic [4:0] hour_value,
  output logic [5:0] minute_value,
  output logic [5:0] second_value,
  output logic [2:0] weekday_number
);

  logic      q_full;
  logic      q_empty;
  logic      rec_push;
  logic      q_pop;
  tspw_rec_t rec;
  tspw_rec_t q_data;

  tspw_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .char_byte      (char_byte),
    .end_of_message (end_of_message),
    .q_full         (q_full),
    .rec_push       (rec_push),
    .rec            (rec)
  );

  tspw_fifo #(.DEPTH(QDEPTH)) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (rec_push),
    .wr_data (rec),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  tspw_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_empty         (q_empty),
    .q_data          (q_data),
    .q_pop           (q_pop),
    .empty           (empty),
    .pop             (pop),
    .accepted        (accepted),
    .year_of_century (year_of_century),
    .month_number    (month_number),
    .day_of_month    (day_of_month),
    .hour_value      (hour_value),
    .minute_value    (minute_value),
    .second_value    (second_value),
    .weekday_number  (weekday_number)
  );

endmodule
